// File: rtl/double_hash_duplicate_filter_macros.svh
// Assertion macros for the duplicate filter
`ifndef DOUBLE_HASH_DUPLICATE_FILTER_MACROS_SVH
`define DOUBLE_HASH_DUPLICATE_FILTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define DHDF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DHDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dhdf_pkg.sv
// Shared constants and state types for the duplicate filter
`default_nettype none

package dhdf_pkg;

    localparam int unsigned KEY_W          = 32;
    localparam int unsigned DEF_TABLE_SIZE = 1024;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned DIGIT_W        = 4;
    localparam int unsigned NUM_DIGITS     = KEY_W / DIGIT_W;
    localparam int unsigned STRIDE_W       = 5;
    localparam int unsigned STRIDE_COUNT   = 1 << STRIDE_W;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CHECK
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/dhdf_front.sv
// Front end: takes an item, works out home slot and probe budget
`default_nettype none

module dhdf_front #(
    parameter int unsigned TABLE_SIZE = dhdf_pkg::DEF_TABLE_SIZE
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [dhdf_pkg::KEY_W-1:0]            key_value,
    input  wire logic                                  hold,
    output logic                                       push_valid,
    input  wire logic                                  push_full,
    output logic [dhdf_pkg::KEY_W-1:0]                 job_key,
    output logic [$clog2(TABLE_SIZE)-1:0]              job_slot,
    output logic [$clog2(TABLE_SIZE+1)-1:0]            job_budget
);

    localparam int unsigned SLOT_W   = $clog2(TABLE_SIZE);
    localparam int unsigned BUDGET_W = $clog2(TABLE_SIZE + 1);
    localparam int unsigned CNT_W    = $clog2(dhdf_pkg::NUM_DIGITS);
    localparam logic [SLOT_W:0]     SIZE_EXT = (SLOT_W + 1)'(TABLE_SIZE);
    localparam logic [CNT_W-1:0]    LAST_DIGIT = CNT_W'(dhdf_pkg::NUM_DIGITS - 1);

    logic [BUDGET_W-1:0] budget_tab [dhdf_pkg::STRIDE_COUNT];

    for (genvar g = 0; g < dhdf_pkg::STRIDE_COUNT; g++) begin : gen_budget
        localparam int unsigned BUDGET_G = TABLE_SIZE / (g + 1);
        assign budget_tab[g] = BUDGET_W'(BUDGET_G);
    end

    dhdf_pkg::front_state_t state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [dhdf_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [dhdf_pkg::KEY_W-1:0]   shift_reg, shift_next;
    logic [SLOT_W-1:0]            rem_reg, rem_next;
    logic [BUDGET_W-1:0]          budget_reg, budget_next;
    logic [SLOT_W:0]              rem_step;

    // radix-16 remainder step, one compare-subtract per bit
    always_comb
    begin
        rem_step = {1'b0, rem_reg};
        for (int i = 0; i < dhdf_pkg::DIGIT_W; i++)
        begin
            rem_step = {rem_step[SLOT_W-1:0], shift_reg[dhdf_pkg::KEY_W-1-i]};
            if (rem_step >= SIZE_EXT)
            begin
                rem_step = rem_step - SIZE_EXT;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        budget_next = budget_reg;
        in_stall    = 1'b1;
        push_valid  = 1'b0;
        unique case (state_reg)
            dhdf_pkg::FR_IDLE:
            begin
                in_stall = hold;
                if (in_valid && !hold)
                begin
                    key_next    = key_value;
                    shift_next  = key_value;
                    rem_next    = '0;
                    cnt_next    = '0;
                    budget_next = budget_tab[key_value[dhdf_pkg::STRIDE_W-1:0]];
                    state_next  = dhdf_pkg::FR_DIV;
                end
            end
            dhdf_pkg::FR_DIV:
            begin
                rem_next   = rem_step[SLOT_W-1:0];
                shift_next = shift_reg << dhdf_pkg::DIGIT_W;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_DIGIT)
                begin
                    state_next = dhdf_pkg::FR_PUSH;
                end
            end
            dhdf_pkg::FR_PUSH:
            begin
                push_valid = 1'b1;
                if (!push_full)
                begin
                    state_next = dhdf_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = dhdf_pkg::FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dhdf_pkg::FR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        shift_reg  <= shift_next;
        rem_reg    <= rem_next;
        budget_reg <= budget_next;
    end

    assign job_key    = key_reg;
    assign job_slot   = rem_reg;
    assign job_budget = budget_reg;

endmodule

`default_nettype wire

// File: rtl/dhdf_queue.sv
// Short job queue between front and back end
`default_nettype none

module dhdf_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = dhdf_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dhdf_back.sv
// Back end: slot memory, clearing pass, probe walk and result register
`default_nettype none

module dhdf_back #(
    parameter int unsigned TABLE_SIZE = dhdf_pkg::DEF_TABLE_SIZE
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  job_valid,
    output logic                                       job_pop,
    input  wire logic [dhdf_pkg::KEY_W-1:0]            job_key,
    input  wire logic [$clog2(TABLE_SIZE)-1:0]         job_slot,
    input  wire logic [$clog2(TABLE_SIZE+1)-1:0]       job_budget,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       is_duplicate,
    output logic                                       overflow,
    output logic                                       clearing
);

    localparam int unsigned SLOT_W   = $clog2(TABLE_SIZE);
    localparam int unsigned BUDGET_W = $clog2(TABLE_SIZE + 1);
    localparam logic [SLOT_W:0]   SIZE_EXT  = (SLOT_W + 1)'(TABLE_SIZE);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

    logic [dhdf_pkg::KEY_W-1:0] slot_mem [TABLE_SIZE];

    dhdf_pkg::back_state_t state_reg, state_next;
    logic [SLOT_W-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [dhdf_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [SLOT_W-1:0]            pos_reg, pos_next;
    logic [BUDGET_W-1:0]          budget_reg, budget_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         dup_reg, dup_next;
    logic                         ovf_reg, ovf_next;
    logic [dhdf_pkg::KEY_W-1:0]   rdata_reg;

    logic                         mem_we;
    logic [SLOT_W-1:0]            mem_waddr;
    logic [dhdf_pkg::KEY_W-1:0]   mem_wdata;
    logic                         mem_re;
    logic [SLOT_W-1:0]            mem_raddr;

    logic                         hit_empty;
    logic                         hit_match;
    logic                         walk_done;
    logic                         out_free;
    logic [dhdf_pkg::STRIDE_W:0]  stride;
    logic [SLOT_W:0]              pos_sum;
    logic [SLOT_W-1:0]            pos_step;

    assign hit_empty = (rdata_reg == '0);
    assign hit_match = (rdata_reg == key_reg);
    assign walk_done = hit_empty || hit_match || (budget_reg == '0);
    assign out_free  = !out_valid_reg || !out_stall;
    assign stride    = {1'b0, key_reg[dhdf_pkg::STRIDE_W-1:0]} + 1'b1;
    assign pos_sum   = {1'b0, pos_reg} + (SLOT_W + 1)'(stride);
    assign pos_step  = (pos_sum >= SIZE_EXT) ? SLOT_W'(pos_sum - SIZE_EXT)
                                             : pos_sum[SLOT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        budget_next    = budget_reg;
        dup_next       = dup_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        job_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = key_reg;
        mem_re         = 1'b0;
        mem_raddr      = pos_step;
        unique case (state_reg)
            dhdf_pkg::BK_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = dhdf_pkg::BK_IDLE;
                end
            end
            dhdf_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop     = 1'b1;
                    mem_re      = 1'b1;
                    mem_raddr   = job_slot;
                    key_next    = job_key;
                    pos_next    = job_slot;
                    budget_next = job_budget;
                    state_next  = dhdf_pkg::BK_CHECK;
                end
            end
            dhdf_pkg::BK_CHECK:
            begin
                if (!walk_done)
                begin
                    // advance to the next probe
                    mem_re      = 1'b1;
                    mem_raddr   = pos_step;
                    pos_next    = pos_step;
                    budget_next = budget_reg - 1'b1;
                end
                else if (out_free)
                begin
                    mem_we         = hit_empty;
                    out_valid_next = 1'b1;
                    dup_next       = !hit_empty && hit_match;
                    ovf_next       = !hit_empty && !hit_match;
                    state_next     = dhdf_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = dhdf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dhdf_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        budget_reg <= budget_next;
        dup_reg    <= dup_next;
        ovf_reg    <= ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= slot_mem[mem_raddr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_duplicate = dup_reg;
    assign overflow     = ovf_reg;
    assign clearing     = (state_reg == dhdf_pkg::BK_CLEAR);

endmodule

`default_nettype wire

// File: rtl/double_hash_duplicate_filter.sv
// Top level of the double-hashing duplicate filter
//
//  Channel  Direction  Handshake             Fields
//  input    in         in_valid / in_stall   key_value[31:0]
//  result   out        out_valid / out_stall is_duplicate, overflow
//
//  Front end per item: accept, 8 radix-16 remainder steps, hand-off; it takes no new item until the hand-off.
//  Back end: one memory read per probe.
//  The queue lets the two ends work on different items at once.
//  After reset a clearing pass writes every slot to zero and holds in_stall high.
//  A stalled result holds the back end only once its walk has finished.
`default_nettype none

`include "double_hash_duplicate_filter_macros.svh"

module double_hash_duplicate_filter #(
    parameter int unsigned TABLE_SIZE = dhdf_pkg::DEF_TABLE_SIZE
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [dhdf_pkg::KEY_W-1:0]  key_value,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             is_duplicate,
    output logic                             overflow
);

    localparam int unsigned SLOT_W   = $clog2(TABLE_SIZE);
    localparam int unsigned BUDGET_W = $clog2(TABLE_SIZE + 1);
    localparam int unsigned JOB_W    = dhdf_pkg::KEY_W + SLOT_W + BUDGET_W;

    logic                        clearing;
    logic                        q_push_valid;
    logic                        q_full;
    logic                        q_pop_valid;
    logic                        q_pop;
    logic [JOB_W-1:0]            q_push_data;
    logic [JOB_W-1:0]            q_pop_data;
    logic [dhdf_pkg::KEY_W-1:0]  f_key;
    logic [SLOT_W-1:0]           f_slot;
    logic [BUDGET_W-1:0]         f_budget;

    dhdf_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_value  (key_value),
        .hold       (clearing),
        .push_valid (q_push_valid),
        .push_full  (q_full),
        .job_key    (f_key),
        .job_slot   (f_slot),
        .job_budget (f_budget)
    );

    assign q_push_data = {f_key, f_slot, f_budget};

    dhdf_queue #(
        .WIDTH (JOB_W),
        .DEPTH (dhdf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_data   (q_pop_data)
    );

    dhdf_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_pop_valid),
        .job_pop      (q_pop),
        .job_key      (q_pop_data[JOB_W-1 -: dhdf_pkg::KEY_W]),
        .job_slot     (q_pop_data[BUDGET_W +: SLOT_W]),
        .job_budget   (q_pop_data[BUDGET_W-1:0]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_duplicate (is_duplicate),
        .overflow     (overflow),
        .clearing     (clearing)
    );

    `DHDF_ASSERT_IMP(a_dup_no_ovf, out_valid && is_duplicate, !overflow, "duplicate with overflow")
    `DHDF_ASSERT_IMP(a_clear_empty_q, clearing, !q_pop_valid, "job queued during clearing")
    `DHDF_ASSERT_IMP(a_clear_no_out, $fell(clearing), !out_valid, "result before clearing done")
    `DHDF_ASSERT_NEXT(a_full_holds, q_full && !q_pop, q_full, "queue lost an entry")

endmodule

`default_nettype wire
